[rtl/core/tmd_pkg.sv]
// Package for the tar member deframer: field offsets, character codes and
// the codes for phase, size parsing and result kinds.
// No dependencies.
package tmd_pkg;

    localparam int BLOCK_BYTES_DEF  = 512;
    localparam int SIZE_BITS_DEF    = 36;

    localparam int NAME_FIELD_BYTES = 100;
    localparam int SIZE_FIELD_START = 124;
    localparam int SIZE_FIELD_END   = 136;
    localparam int MEMBER_SIZE_W    = 36;

    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_size_mode;
    typedef logic [1:0] t_kind;

    localparam t_phase PH_HEADER  = 2'd0;
    localparam t_phase PH_CONTENT = 2'd1;
    localparam t_phase PH_PAD     = 2'd2;

    localparam t_size_mode SP_SKIP   = 2'd0;
    localparam t_size_mode SP_DIGITS = 2'd1;
    localparam t_size_mode SP_DONE   = 2'd2;

    localparam t_kind KIND_NAME    = 2'd0;
    localparam t_kind KIND_SIZE    = 2'd1;
    localparam t_kind KIND_CONTENT = 2'd2;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DOT   = 8'h2e;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SEVEN = 8'h37;

endpackage

[rtl/core/tar_member_deframer.sv]
// A result is registered and appears in the cycle after the word that causes it is accepted.
// Throughput: one input word per cycle; the output register holds a result while
// the next word is accepted in the same cycle that the result is taken.
// The only limit is the output register: a word waits while a result is stalled.
// Reset (synchronous, active low) returns the parser to the start of a header
// block and empties the output register.
// Tar member deframer top level; depends on tmd_pkg.
module tar_member_deframer #(
    parameter int BLOCK_BYTES = tmd_pkg::BLOCK_BYTES_DEF,
    parameter int SIZE_BITS   = tmd_pkg::SIZE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_in_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_record_kind,
    output logic [7:0]                       o_out_byte,
    output logic [tmd_pkg::MEMBER_SIZE_W-1:0] o_member_size,
    output logic                             o_last_of_member
);

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_BYTES - 1);
    localparam int MS_W = tmd_pkg::MEMBER_SIZE_W;

    tmd_pkg::t_phase     r_phase, n_phase;
    logic [OFF_W-1:0]    r_block_offset, n_block_offset;
    logic                r_keep_member, n_keep_member;
    logic                r_name_ended, n_name_ended;
    tmd_pkg::t_size_mode r_size_mode, n_size_mode;
    logic [SIZE_BITS-1:0] r_size_acc, n_size_acc;
    logic [SIZE_BITS-1:0] r_bytes_rem, n_bytes_rem;

    logic                r_out_valid;
    tmd_pkg::t_kind      r_kind, n_kind;
    logic [7:0]          r_out_byte, n_out_byte;
    logic [MS_W-1:0]     r_member_size, n_member_size;
    logic                r_last, n_last;
    logic                n_emit;

    logic                w_accept;
    logic [31:0]         w_off32;
    logic                w_first;
    logic                w_keep;
    logic                w_name_ended;
    tmd_pkg::t_size_mode w_mode;
    logic [SIZE_BITS-1:0] w_acc;
    logic                w_octal;
    logic [MS_W+SIZE_BITS-1:0] w_acc_ext;
    logic [MS_W+SIZE_BITS-1:0] w_cur_ext;
    logic [OFF_W-1:0]    w_off_adv;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_off32    = 32'(r_block_offset);
    assign w_first    = (r_block_offset == '0);
    assign w_octal    = (i_in_byte >= tmd_pkg::CHR_ZERO) && (i_in_byte <= tmd_pkg::CHR_SEVEN);
    assign w_off_adv  = (r_block_offset == OFF_LAST) ? '0 : r_block_offset + 1'b1;
    assign w_cur_ext  = {{MS_W{1'b0}}, r_size_acc};

    always_comb begin
        n_phase        = r_phase;
        n_block_offset = r_block_offset;
        n_keep_member  = r_keep_member;
        n_name_ended   = r_name_ended;
        n_size_mode    = r_size_mode;
        n_size_acc     = r_size_acc;
        n_bytes_rem    = r_bytes_rem;
        n_emit         = 1'b0;
        n_kind         = tmd_pkg::KIND_NAME;
        n_out_byte     = i_in_byte;
        n_member_size  = '0;
        n_last         = 1'b0;
        w_keep         = r_keep_member;
        w_name_ended   = r_name_ended;
        w_mode         = r_size_mode;
        w_acc          = r_size_acc;
        w_acc_ext      = '0;

        unique case (r_phase)
            tmd_pkg::PH_HEADER: begin
                if (w_first) begin
                    w_keep       = (i_in_byte != tmd_pkg::CHR_NUL) &&
                                   (i_in_byte != tmd_pkg::CHR_DOT);
                    w_name_ended = 1'b0;
                    w_mode       = tmd_pkg::SP_SKIP;
                    w_acc        = '0;
                end
                n_keep_member = w_keep;
                n_name_ended  = w_name_ended;
                n_size_mode   = w_mode;
                n_size_acc    = w_acc;

                if (w_off32 < 32'(tmd_pkg::NAME_FIELD_BYTES) && !w_name_ended) begin
                    if (i_in_byte == tmd_pkg::CHR_NUL) begin
                        n_name_ended = 1'b1;
                    end else if (w_keep) begin
                        n_emit = 1'b1;
                    end
                end
                if (w_off32 + 32'd1 >= 32'(tmd_pkg::NAME_FIELD_BYTES)) begin
                    n_name_ended = 1'b1;
                end

                if (w_off32 >= 32'(tmd_pkg::SIZE_FIELD_START) &&
                    w_off32 < 32'(tmd_pkg::SIZE_FIELD_END) &&
                    w_mode != tmd_pkg::SP_DONE &&
                    !(w_mode == tmd_pkg::SP_SKIP && i_in_byte == tmd_pkg::CHR_SPACE)) begin
                    if (!w_octal) begin
                        n_size_mode = tmd_pkg::SP_DONE;
                    end else begin
                        n_size_mode = tmd_pkg::SP_DIGITS;
                        if (|w_acc[SIZE_BITS-1:SIZE_BITS-3]) begin
                            n_size_acc = '1;
                        end else begin
                            n_size_acc = {w_acc[SIZE_BITS-4:0], i_in_byte[2:0]};
                        end
                    end
                end

                if (r_block_offset == OFF_LAST) begin
                    w_acc_ext      = {{MS_W{1'b0}}, n_size_acc};
                    n_emit         = w_keep;
                    n_kind         = tmd_pkg::KIND_SIZE;
                    n_out_byte     = '0;
                    n_member_size  = w_acc_ext[MS_W-1:0];
                    n_last         = (n_size_acc == '0);
                    n_block_offset = '0;
                    n_bytes_rem    = n_size_acc;
                    n_phase        = (n_size_acc == '0) ? tmd_pkg::PH_HEADER
                                                        : tmd_pkg::PH_CONTENT;
                end else begin
                    n_block_offset = r_block_offset + 1'b1;
                end
            end
            tmd_pkg::PH_CONTENT: begin
                n_bytes_rem    = (r_bytes_rem != '0) ? r_bytes_rem - 1'b1 : r_bytes_rem;
                n_emit         = r_keep_member;
                n_kind         = tmd_pkg::KIND_CONTENT;
                n_member_size  = w_cur_ext[MS_W-1:0];
                n_last         = (n_bytes_rem == '0);
                n_block_offset = w_off_adv;
                if (n_bytes_rem == '0) begin
                    n_phase = (w_off_adv == '0) ? tmd_pkg::PH_HEADER : tmd_pkg::PH_PAD;
                end
            end
            default: begin
                n_block_offset = w_off_adv;
                if (w_off_adv == '0) begin
                    n_phase = tmd_pkg::PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tmd_pkg::PH_HEADER;
            r_block_offset <= '0;
            r_keep_member  <= 1'b0;
            r_name_ended   <= 1'b0;
            r_size_mode    <= tmd_pkg::SP_SKIP;
            r_size_acc     <= '0;
            r_bytes_rem    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_block_offset <= n_block_offset;
                r_keep_member  <= n_keep_member;
                r_name_ended   <= n_name_ended;
                r_size_mode    <= n_size_mode;
                r_size_acc     <= n_size_acc;
                r_bytes_rem    <= n_bytes_rem;
            end
            if (o_in_ready) begin
                r_out_valid <= w_accept && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_kind        <= n_kind;
            r_out_byte    <= n_out_byte;
            r_member_size <= n_member_size;
            r_last        <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_record_kind    = r_kind;
    assign o_out_byte       = r_out_byte;
    assign o_member_size    = r_member_size;
    assign o_last_of_member = r_last;

    a_name_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == tmd_pkg::KIND_NAME
        |-> o_member_size == '0 && !o_last_of_member)
        else $error("name word carries size or last flag");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_record_kind <= tmd_pkg::KIND_CONTENT)
        else $error("undefined result kind");

    a_size_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == tmd_pkg::KIND_SIZE |-> o_out_byte == '0)
        else $error("size word with nonzero byte");

    a_content_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tmd_pkg::PH_CONTENT |-> r_bytes_rem != '0)
        else $error("content phase with no bytes remaining");

    a_content_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == tmd_pkg::PH_CONTENT && r_bytes_rem == SIZE_BITS'(1)
        |=> r_phase != tmd_pkg::PH_CONTENT)
        else $error("content phase did not end after last byte");

endmodule
